FILE: rtl/set_assoc_lru_tag_directory_defines.svh
// Assertion macros for the set-associative LRU tag directory.
// Included by the directory top level; needs a clk and an rst in scope.
`ifndef SET_ASSOC_LRU_TAG_DIRECTORY_DEFINES_SVH
`define SET_ASSOC_LRU_TAG_DIRECTORY_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property outside reset
`define SALRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property that covers reset itself
`define SALRU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SALRU_ASSERT(label, prop, msg)
`define SALRU_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: rtl/salru_pkg.sv
// Shared constants for the set-associative LRU tag directory.
// No dependencies; used by set_assoc_lru_tag_directory.
`default_nettype none

package salru_pkg;

  localparam int MAX_SETS   = 64;
  localparam int MAX_WAYS   = 4;
  localparam int ADDR_WIDTH = 32;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_BLOCK_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS   = 2'd1;
  localparam logic [1:0] REG_WAYS_USED  = 2'd2;

  localparam logic [3:0] BLOCK_BITS_RST = 4'd6;
  localparam logic [2:0] SET_BITS_RST   = 3'd6;
  localparam logic [2:0] WAYS_USED_RST  = 3'd4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  localparam logic [63:0] USE_COUNTER_RST = 64'd1;

endpackage

`default_nettype wire

FILE: rtl/set_assoc_lru_tag_directory.sv
// Set-associative tag directory with LRU replacement by use stamps.
// Uses salru_pkg and set_assoc_lru_tag_directory_defines.svh.
//
// Usage:
//   Requests enter on req_valid/req_ready with opcode, address and req_size.
//   A lookup (OP_LOOKUP) that hits answers the CPU with hit and way_used;
//   one that misses sets to_memory and forwards address and size. A fill
//   (OP_FILL) installs the line in the least recently stamped way of its set
//   (or restamps it when present) and answers the CPU with way_used.
//   Responses leave on rsp_valid/rsp_ready, one per request, in order.
//   From acceptance, the set row is read from the tag and stamp memories
//   into the request register, and the compare, victim pick and row write
//   finish into the response register. Throughput is one request per
//   cycle while the response is not stalled, set by the single row write
//   port of each memory; a same-set write is bypassed into the next read.
//   Reset empties the pipeline, clears all valid bits (invalid ways read as
//   stamp zero), sets the use counter to one and loads the default
//   configuration; no clearing pass is needed.
//   When rsp_ready is low the response holds, one more request may enter
//   the request register, and req_ready then drops until the stall clears.
//   Configuration writes go through the APB port while no request is open.
`default_nettype none

module set_assoc_lru_tag_directory #(
  parameter int MAX_SETS   = salru_pkg::MAX_SETS,
  parameter int MAX_WAYS   = salru_pkg::MAX_WAYS,
  parameter int ADDR_WIDTH = salru_pkg::ADDR_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [salru_pkg::PADDR_W-1:0] paddr,
  input  wire logic [salru_pkg::PDATA_W-1:0] pwdata,
  output logic      [salru_pkg::PDATA_W-1:0] prdata,
  output logic                               pready,

  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire logic                          opcode,
  input  wire logic [31:0]                   address,
  input  wire logic [7:0]                    req_size,

  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output logic                               to_memory,
  output logic      [31:0]                   out_address,
  output logic      [7:0]                    out_size,
  output logic                               hit,
  output logic      [1:0]                    way_used
);

`include "set_assoc_lru_tag_directory_defines.svh"

  localparam int IDX_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int MSB_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? '1 : ((32'd1 << ADDR_WIDTH) - 32'd1);

  typedef logic [MAX_WAYS-1:0][31:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][63:0] stamp_row_t;

  logic [3:0]  block_bits;
  logic [2:0]  set_bits;
  logic [2:0]  ways_used;
  logic [63:0] use_counter;

  tag_row_t              tag_mem   [MAX_SETS];
  stamp_row_t            stamp_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]   valid_bits [MAX_SETS];

  logic             s1_valid;
  logic             s1_opcode;
  logic [31:0]      s1_address;
  logic [7:0]       s1_size;
  logic [IDX_W-1:0] s1_set;
  logic [31:0]      s1_tag;
  tag_row_t         tag_rd;
  stamp_row_t       stamp_rd;

  logic             cfg_write;
  logic [3:0]       sb;
  logic [4:0]       nways;
  logic [4:0]       ways_ext;
  logic [MAX_WAYS-1:0] active;
  logic [31:0]      addr_m;
  logic [31:0]      set_full;
  logic [IDX_W-1:0] req_set;
  logic [31:0]      req_tag;

  logic             accept;
  logic             commit;
  logic             upd;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] victim_oh;
  stamp_row_t       stamp_eff;
  logic             found;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] way_sel;
  tag_row_t         tag_row_new;
  stamp_row_t       stamp_row_new;
  logic [63:0]      use_counter_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      salru_pkg::REG_BLOCK_BITS: prdata = {28'd0, block_bits};
      salru_pkg::REG_SET_BITS:   prdata = {29'd0, set_bits};
      salru_pkg::REG_WAYS_USED:  prdata = {29'd0, ways_used};
      default:                   prdata = '0;
    endcase
  end

  // effective geometry
  always_comb begin
    sb = ({1'b0, set_bits} > 4'(MSB_BITS)) ? 4'(MSB_BITS) : {1'b0, set_bits};
    ways_ext = {2'b00, ways_used};
    if (ways_ext == 5'd0) begin
      nways = 5'd1;
    end else if (ways_ext > 5'(MAX_WAYS)) begin
      nways = 5'(MAX_WAYS);
    end else begin
      nways = ways_ext;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w] = 5'(w) < nways;
    end
  end

  // split the incoming address
  always_comb begin
    addr_m   = address & ADDR_MASK;
    set_full = (addr_m >> block_bits) & ((32'd1 << sb) - 32'd1);
    req_set  = set_full[IDX_W-1:0];
    req_tag  = addr_m >> ({1'b0, block_bits} + {1'b0, sb});
  end

  // handshake
  assign commit    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || commit;
  assign accept    = req_valid && req_ready;

  // tag compare and victim pick
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w]     = valid_bits[s1_set][w] && active[w] && (tag_rd[w] == s1_tag);
      stamp_eff[w] = valid_bits[s1_set][w] ? stamp_rd[w] : 64'd0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      victim_oh[w] = active[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v < w && active[v]) begin
          victim_oh[w] = victim_oh[w] && (stamp_eff[w] < stamp_eff[v]);
        end else if (v > w && active[v]) begin
          victim_oh[w] = victim_oh[w] && (stamp_eff[w] <= stamp_eff[v]);
        end
      end
    end
    found      = |match;
    hit_way    = '0;
    victim_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (victim_oh[w]) begin
        victim_way = victim_way | WAY_W'(w);
      end
    end
    way_sel = found ? hit_way : victim_way;

    upd = commit && ((s1_opcode == salru_pkg::OP_FILL) || found);
    tag_row_new   = tag_rd;
    stamp_row_new = stamp_eff;
    if ((s1_opcode == salru_pkg::OP_FILL) && !found) begin
      tag_row_new[way_sel] = s1_tag;
    end
    stamp_row_new[way_sel] = use_counter;
    use_counter_next = use_counter + 64'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
      use_counter <= salru_pkg::USE_COUNTER_RST;
      block_bits  <= salru_pkg::BLOCK_BITS_RST;
      set_bits    <= salru_pkg::SET_BITS_RST;
      ways_used   <= salru_pkg::WAYS_USED_RST;
      for (int s = 0; s < MAX_SETS; s++) begin
        valid_bits[s] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          salru_pkg::REG_BLOCK_BITS: block_bits <= pwdata[3:0];
          salru_pkg::REG_SET_BITS:   set_bits   <= pwdata[2:0];
          salru_pkg::REG_WAYS_USED:  ways_used  <= pwdata[2:0];
          default: ;
        endcase
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (upd) begin
        use_counter <= use_counter_next;
      end
      if (upd && (s1_opcode == salru_pkg::OP_FILL)) begin
        valid_bits[s1_set][way_sel] <= 1'b1;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode  <= opcode;
      s1_address <= address;
      s1_size    <= req_size;
      s1_set     <= req_set;
      s1_tag     <= req_tag;
    end
  end

  // tag and stamp rows: write back on update, read with same-set bypass
  always_ff @(posedge clk) begin
    if (upd) begin
      tag_mem[s1_set]   <= tag_row_new;
      stamp_mem[s1_set] <= stamp_row_new;
    end
    if (accept) begin
      if (upd && (s1_set == req_set)) begin
        tag_rd   <= tag_row_new;
        stamp_rd <= stamp_row_new;
      end else begin
        tag_rd   <= tag_mem[req_set];
        stamp_rd <= stamp_mem[req_set];
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (commit) begin
      to_memory   <= (s1_opcode == salru_pkg::OP_LOOKUP) && !found;
      hit         <= (s1_opcode == salru_pkg::OP_LOOKUP) && found;
      out_address <= s1_address;
      out_size    <= s1_size;
      if ((s1_opcode == salru_pkg::OP_LOOKUP) && !found) begin
        way_used <= 2'd0;
      end else begin
        way_used <= 2'(way_sel);
      end
    end
  end

  `SALRU_ASSERT(a_victim_onehot, s1_valid |-> $onehot(victim_oh), "victim pick not one-hot")
  `SALRU_ASSERT(a_counter_step, upd |=> (use_counter == $past(use_counter) + 64'd1), "use counter skipped")
  `SALRU_ASSERT(a_counter_hold, !upd |=> $stable(use_counter), "use counter moved without update")
  `SALRU_ASSERT_RST(a_reset_empty, rst |=> (!s1_valid && !rsp_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire
